// File: rtl/ofr_pkg.sv
// Package for the orifice flow rate unit: field widths, fixed-point constants,
// register indexes and area modes. No dependencies.

package ofr_pkg;

  // Field and register widths
  localparam int unsigned PIN_W      = 28;
  localparam int unsigned OPEN_W     = 31;
  localparam int unsigned FC_W       = 40;
  localparam int unsigned BORE_W     = 30;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned FLOW_W     = 64;
  localparam int unsigned AREA_W     = 63;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  // Internal widths
  localparam int unsigned DP_W   = 28;   // |pin - pout| < 2^28
  localparam int unsigned O_W    = 30;   // clamped opening
  localparam int unsigned ROOT_W = 30;   // sqrt(dp * 2^32) < 2^30

  // Constant divider by 15625, one 16-bit digit per step
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned REM_W     = 14;
  localparam int unsigned CUR_W     = REM_W + CHUNK_W;
  localparam int unsigned DIVM_W    = 31;
  localparam int unsigned PROD_W    = CUR_W + DIVM_W;
  localparam int unsigned DIV_SHIFT = 44;
  localparam logic [DIVM_W-1:0] DIV_M = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam logic [REM_W-1:0]  DIV_D = 14'd15625;

  // Fixed-point constants
  localparam logic [32:0] SQRT2_Q32 = 33'h16A09E668;
  localparam logic [62:0] PI_Q61    = 63'h6487ED5110B4611A;
  localparam logic [DP_W-1:0] DP_REG = 28'd10000;
  localparam logic [14:0] QUAD_SPAN = 15'd30000;
  localparam logic [12:0] QUAD_BIAS = 13'd7812;   // floor(1e6 / 128)

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_COEFF    = 2'd0,
    CFG_BORE_DIAMETER = 2'd1,
    CFG_AREA_MODE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONE   = 2'd0,
    MODE_PISTON = 2'd1
  } area_mode_e;

endpackage

// File: rtl/ofr_delay.sv
// Delay line of registers for pipeline alignment, advanced by a stage enable.
// No dependencies.

module ofr_delay #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int unsigned i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

// File: rtl/ofr_cdiv.sv
// Pipelined division by 15625, one 16-bit digit per step in two register stages
// (reciprocal multiply, then remainder). Depends on ofr_pkg.

module ofr_cdiv #(
  parameter int unsigned Chunks = 2
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [Chunks*ofr_pkg::CHUNK_W-1:0]  num_i,
  output logic [Chunks*ofr_pkg::CHUNK_W-1:0]  quo_o
);
  import ofr_pkg::*;

  localparam int unsigned W = Chunks * CHUNK_W;

  logic [W-1:0]     num_a [Chunks+1];
  logic [W-1:0]     quo_a [Chunks+1];
  logic [REM_W-1:0] rem_a [Chunks+1];

  assign num_a[0] = num_i;
  assign quo_a[0] = '0;
  assign rem_a[0] = '0;

  for (genvar k = 0; k < Chunks; k++) begin : g_digit
    localparam int unsigned C = Chunks - 1 - k;

    logic [CUR_W-1:0]   cur;
    logic [CUR_W-1:0]   cur_q;
    logic [PROD_W-1:0]  prod_q;
    logic [W-1:0]       num_q, quo_q;
    logic [CHUNK_W-1:0] dig;
    logic [CUR_W-1:0]   back;
    logic [W-1:0]       quo_nx;
    logic [W-1:0]       num_q2, quo_q2;
    logic [REM_W-1:0]   rem_q2;

    assign cur = {rem_a[k], num_a[k][C*CHUNK_W +: CHUNK_W]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cur_q  <= cur;
        prod_q <= PROD_W'(cur) * PROD_W'(DIV_M);
        num_q  <= num_a[k];
        quo_q  <= quo_a[k];
      end
    end

    assign dig  = prod_q[DIV_SHIFT +: CHUNK_W];
    assign back = CUR_W'(dig) * CUR_W'(DIV_D);

    always_comb begin
      quo_nx = quo_q;
      quo_nx[C*CHUNK_W +: CHUNK_W] = dig;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q2 <= REM_W'(cur_q - back);
        num_q2 <= num_q;
        quo_q2 <= quo_nx;
      end
    end

    assign num_a[k+1] = num_q2;
    assign quo_a[k+1] = quo_q2;
    assign rem_a[k+1] = rem_q2;
  end

  assign quo_o = quo_a[Chunks];

endmodule

// File: rtl/ofr_sqrt.sv
// Pipelined integer square root of dp * 2^32, one root bit per register stage.
// Depends on ofr_pkg.

module ofr_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ofr_pkg::DP_W-1:0]    dp_i,
  output logic [ofr_pkg::ROOT_W-1:0]  root_o
);
  import ofr_pkg::*;

  localparam int unsigned N_W  = 2 * ROOT_W;
  localparam int unsigned RM_W = ROOT_W + 2;

  logic [N_W-1:0]    n_a   [ROOT_W+1];
  logic [RM_W-1:0]   rem_a [ROOT_W+1];
  logic [ROOT_W-1:0] r_a   [ROOT_W+1];

  assign n_a[0]   = {dp_i, {(N_W-DP_W){1'b0}}};
  assign rem_a[0] = '0;
  assign r_a[0]   = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    logic [RM_W+1:0]   rem_sh, trial;
    logic              ge;
    logic [N_W-1:0]    n_q;
    logic [RM_W-1:0]   rem_q;
    logic [ROOT_W-1:0] r_q;

    assign rem_sh = {rem_a[k], n_a[k][N_W-1 -: 2]};
    assign trial  = {2'b00, r_a[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q   <= {n_a[k][N_W-3:0], 2'b00};
        rem_q <= ge ? RM_W'(rem_sh - trial) : RM_W'(rem_sh);
        r_q   <= {r_a[k][ROOT_W-2:0], ge};
      end
    end

    assign n_a[k+1]   = n_q;
    assign rem_a[k+1] = rem_q;
    assign r_a[k+1]   = r_q;
  end

  assign root_o = r_a[ROOT_W];

endmodule

// File: rtl/orifice_flow_rate_unit.sv
// Orifice flow rate unit, top level: configuration registers, area and flow
// pipeline, output register with skid. Depends on ofr_pkg, ofr_delay, ofr_cdiv, ofr_sqrt.
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pressures, opening
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: flow, area; tuser: mode error
//   cfg       in   cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// One item per cycle while the skid register is empty; a result passes the
// 30-stage square root, then the 80-bit product and five divider digits.
// Reset clears valid bits and configuration; no clearing pass.
// A stall at the output parks one result in a skid register; the pipeline
// freezes only while that register is full.

module orifice_flow_rate_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ofr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ofr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [27:0] inflow_pressure, [55:28] outflow_pressure, [86:56] valve_opening, [87] zero
  input  logic [87:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [63:0] flow_rate, [126:64] open_area, [127] zero
  output logic [127:0]                     m_axis_tdata,
  // [0] mode_error
  output logic                             m_axis_tuser
);
  import ofr_pkg::*;

  localparam int unsigned PIPE_DEPTH = 44;

  // Configuration
  logic [FC_W-1:0]   flow_coeff_q;
  logic [BORE_W-1:0] bore_q;
  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_coeff_q <= '0;
      bore_q       <= '0;
      mode_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FLOW_COEFF:    flow_coeff_q <= cfg_data_i[FC_W-1:0];
        CFG_BORE_DIAMETER: bore_q       <= cfg_data_i[BORE_W-1:0];
        CFG_AREA_MODE:     mode_q       <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enable and valid chain
  logic                  en;
  logic                  skid_vld_q, out_vld_q;
  logic [PIPE_DEPTH:1]   vld_q;

  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-1:1], s_axis_tvalid};
    end
  end

  // Stage 1: difference, sign, clamped opening
  logic [PIN_W:0]  pin_x, pout_x, diff;
  logic [DP_W-1:0] dp_d;
  logic [O_W-1:0]  o_d;

  assign pin_x  = {s_axis_tdata[PIN_W-1], s_axis_tdata[PIN_W-1:0]};
  assign pout_x = {s_axis_tdata[2*PIN_W-1], s_axis_tdata[2*PIN_W-1:PIN_W]};
  assign diff   = pin_x - pout_x;
  assign dp_d   = diff[PIN_W] ? DP_W'(~diff + 1'b1) : DP_W'(diff);
  assign o_d    = s_axis_tdata[2*PIN_W+OPEN_W-1] ? '0 : s_axis_tdata[2*PIN_W +: O_W];

  logic [DP_W-1:0] s1_dp_q;
  logic [O_W-1:0]  s1_o_q;
  logic            s1_neg_q, s1_err_q, s1_pst_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dp_q  <= dp_d;
      s1_o_q   <= o_d;
      s1_neg_q <= diff[PIN_W];
      s1_err_q <= (mode_q > MODE_PISTON);
      s1_pst_q <= (mode_q == MODE_PISTON);
    end
  end

  // Stage 2: cone and piston products; quadratic blend numerator
  logic [62:0]     a1_po_q;
  logic [59:0]     a1_tp_q;
  logic [O_W-1:0]  a1_o_q;
  logic            a1_pst_q;
  logic [47:0]     q1_z_q;
  logic            q1_big_q;
  logic [13:0]     dp14;
  logic [14:0]     span_m;
  logic [28:0]     quad_x;

  assign dp14   = s1_dp_q[13:0];
  assign span_m = QUAD_SPAN - {1'b0, dp14};
  assign quad_x = 29'(dp14) * 29'(span_m);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_po_q  <= 63'(s1_o_q) * 63'(SQRT2_Q32);
      a1_tp_q  <= 60'(bore_q) * 60'(s1_o_q);
      a1_o_q   <= s1_o_q;
      a1_pst_q <= s1_pst_q;
      q1_z_q   <= 48'({quad_x, 9'b0}) + 48'(QUAD_BIAS);
      q1_big_q <= (s1_dp_q > DP_REG);
    end
  end

  // Stage 3: cone inner term
  logic [63:0]    a2_inner_q;
  logic [59:0]    a2_tp_q;
  logic [O_W-1:0] a2_o_q;
  logic           a2_pst_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_inner_q <= 64'({bore_q, 32'b0}) + 64'(a1_po_q);
      a2_tp_q    <= a1_tp_q;
      a2_o_q     <= a1_o_q;
      a2_pst_q   <= a1_pst_q;
    end
  end

  // Stage 4: opening times inner, two halves
  logic [61:0] a3_plo_q, a3_phi_q;
  logic [59:0] a3_tp_q;
  logic        a3_pst_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_plo_q <= 62'(a2_o_q) * 62'(a2_inner_q[31:0]);
      a3_phi_q <= 62'(a2_o_q) * 62'(a2_inner_q[63:32]);
      a3_tp_q  <= a2_tp_q;
      a3_pst_q <= a2_pst_q;
    end
  end

  // Stage 5: area term t
  logic [61:0] a4_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_t_q <= a3_pst_q ? 62'(a3_tp_q) : a3_phi_q + 62'(a3_plo_q[61:32]);
    end
  end

  // Stage 6: t times pi, partial products
  logic [63:0] pp00_q;
  logic [62:0] pp01_q;
  logic [61:0] pp10_q;
  logic [60:0] pp11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp00_q <= 64'(a4_t_q[31:0]) * 64'(PI_Q61[31:0]);
      pp01_q <= 63'(a4_t_q[31:0]) * 63'(PI_Q61[62:32]);
      pp10_q <= 62'(a4_t_q[61:32]) * 62'(PI_Q61[31:0]);
      pp11_q <= 61'(a4_t_q[61:32]) * 61'(PI_Q61[62:32]);
    end
  end

  // Stage 7: round and saturate area
  logic [125:0]      pi_full;
  logic [AREA_W-1:0] area_q;

  assign pi_full = 126'(pp00_q) + (126'(pp01_q) << 32) + (126'(pp10_q) << 32)
                 + (126'(pp11_q) << 64) + (126'(1) << 60);

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q <= (pi_full[125:124] != 2'b00) ? {AREA_W{1'b1}} : pi_full[123:61];
    end
  end

  // Stages 8-9: area times flow coefficient
  logic [63:0]  af00_q;
  logic [39:0]  af01_q;
  logic [62:0]  af10_q;
  logic [38:0]  af11_q;
  logic [102:0] af_q, af_dly;

  always_ff @(posedge clk_i) begin
    if (en) begin
      af00_q <= 64'(area_q[31:0]) * 64'(flow_coeff_q[31:0]);
      af01_q <= 40'(area_q[31:0]) * 40'(flow_coeff_q[39:32]);
      af10_q <= 63'(area_q[62:32]) * 63'(flow_coeff_q[31:0]);
      af11_q <= 39'(area_q[62:32]) * 39'(flow_coeff_q[39:32]);
      af_q   <= 103'(af00_q) + (103'(af01_q) << 32) + (103'(af10_q) << 32)
              + (103'(af11_q) << 64);
    end
  end

  ofr_delay #(.Width(103), .Depth(23)) u_af_dly (
    .clk_i(clk_i), .en_i(en), .d_i(af_q), .q_o(af_dly)
  );

  // Root: exact square root above the blend threshold, quadratic below
  logic [ROOT_W-1:0] root;
  logic [47:0]       quad_quo;
  logic [ROOT_W-1:0] quad_dly;
  logic              big_dly;
  logic [ROOT_W-1:0] s_q;

  ofr_sqrt u_sqrt (
    .clk_i(clk_i), .en_i(en), .dp_i(s1_dp_q), .root_o(root)
  );

  ofr_cdiv #(.Chunks(3)) u_quad_div (
    .clk_i(clk_i), .en_i(en), .num_i(q1_z_q), .quo_o(quad_quo)
  );

  ofr_delay #(.Width(ROOT_W), .Depth(23)) u_quad_dly (
    .clk_i(clk_i), .en_i(en), .d_i(quad_quo[ROOT_W-1:0]), .q_o(quad_dly)
  );

  ofr_delay #(.Width(1), .Depth(29)) u_big_dly (
    .clk_i(clk_i), .en_i(en), .d_i(q1_big_q), .q_o(big_dly)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= big_dly ? root : quad_dly;
    end
  end

  // Stages 33-34: product with root, scale by 2^-54
  logic [61:0]  m0_q, m1_q, m2_q;
  logic [36:0]  m3_q;
  logic [133:0] prod_full;
  logic [79:0]  x_q, quo;

  assign prod_full = 134'(m0_q) + (134'(m1_q) << 32) + (134'(m2_q) << 64)
                   + (134'(m3_q) << 96);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q <= 62'(af_dly[31:0]) * 62'(s_q);
      m1_q <= 62'(af_dly[63:32]) * 62'(s_q);
      m2_q <= 62'(af_dly[95:64]) * 62'(s_q);
      m3_q <= 37'(af_dly[102:96]) * 37'(s_q);
      x_q  <= prod_full[133:54];
    end
  end

  // Stages 35-44: divide by 15625
  ofr_cdiv #(.Chunks(5)) u_flow_div (
    .clk_i(clk_i), .en_i(en), .num_i(x_q), .quo_o(quo)
  );

  // Side information aligned to the divider output
  logic [1:0]        side_dly;
  logic [AREA_W-1:0] area_dly;

  ofr_delay #(.Width(2), .Depth(43)) u_side_dly (
    .clk_i(clk_i), .en_i(en), .d_i({s1_err_q, s1_neg_q}), .q_o(side_dly)
  );

  ofr_delay #(.Width(AREA_W), .Depth(37)) u_area_dly (
    .clk_i(clk_i), .en_i(en), .d_i(area_q), .q_o(area_dly)
  );

  // Sign and saturate
  logic [FLOW_W-1:0] mag, flow;
  logic [127:0]      res_data;

  always_comb begin
    if (side_dly[0]) begin
      mag  = ((quo[79:64] != '0) || (quo[63:0] > {1'b1, 63'b0})) ? {1'b1, 63'b0}
                                                                  : quo[63:0];
      flow = ~mag + 1'b1;
    end else begin
      mag  = (quo[79:63] != '0) ? {1'b0, {(FLOW_W-1){1'b1}}} : quo[63:0];
      flow = mag;
    end
    res_data = side_dly[1] ? '0 : {1'b0, area_dly, flow};
  end

  // Output register and skid
  logic [127:0] out_data_q, skid_data_q;
  logic         out_user_q, skid_user_q;
  logic         out_vld_d, skid_vld_d, load_out, load_skid, from_skid;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    from_skid  = 1'b0;
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        from_skid  = 1'b1;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_d = vld_q[PIPE_DEPTH];
      load_out  = vld_q[PIPE_DEPTH];
    end else if (vld_q[PIPE_DEPTH]) begin
      skid_vld_d = 1'b1;
      load_skid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end else if (load_out) begin
      out_data_q <= res_data;
      out_user_q <= side_dly[1];
    end
    if (load_skid) begin
      skid_data_q <= res_data;
      skid_user_q <= side_dly[1];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: rtl/ofr_checker.sv
// Port-level checks on the result channel of the orifice flow rate unit,
// bound to the top level. Depends on orifice_flow_rate_unit.

module ofr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid_i,
  input logic         m_tready_i,
  input logic [127:0] m_tdata_i,
  input logic         m_tuser_i
);

  // hold a stalled result
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("stalled result changed");

  // bad area mode gives zero flow and zero area
  a_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> m_tdata_i == 128'b0)
    else $error("mode error with nonzero payload");

  // no area, no flow
  a_area_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[126:64] == 63'b0) |-> m_tdata_i[63:0] == 64'b0)
    else $error("flow without open area");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> !m_tdata_i[127])
    else $error("pad bit set");

endmodule

bind orifice_flow_rate_unit ofr_checker u_ofr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid),
  .m_tready_i(m_axis_tready),
  .m_tdata_i (m_axis_tdata),
  .m_tuser_i (m_axis_tuser)
);
